>>> rtl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg - shared types and constants of the palette dither
// widths, register indexes, controller command and status bundles
// ----------------------------------------------------------------------------
package fsd_pkg;

	localparam int MaxWidth     = 1024;
	localparam int PaletteDepth = 64;
	localparam int RowLimit     = 4096;
	localparam int ColW         = $clog2(MaxWidth);
	localparam int PalW         = $clog2(PaletteDepth);
	localparam int RowW         = $clog2(RowLimit);
	localparam int CfgW         = 13;

	localparam logic [1:0] RegWidth   = 2'd0;
	localparam logic [1:0] RegHeight  = 2'd1;
	localparam logic [1:0] RegPalSize = 2'd2;

	localparam logic OpPalette = 1'b0;
	localparam logic OpPixel   = 1'b1;

	typedef logic signed [9:0] err_t;   // a signed error term, within -255..255 scaled
	typedef struct packed {
		err_t t1;
		err_t t5;
		err_t t3;
	} line_ch_t;
	typedef line_ch_t [2:0] line_word_t;

	typedef struct packed {
		logic load;     // read the line memory word of the current column
		logic adjust;   // add the diffused terms
		logic search;   // compare one palette entry
		logic finish;   // form error, update line, load output
	} cmd_t;

	typedef struct packed {
		logic search_last;
		logic skip;
	} sts_t;

	function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
		if (v < 0) return 8'd0;
		if (v > 11'sd255) return 8'd255;
		return v[7:0];
	endfunction

	// signed divide by 16 toward zero
	function automatic err_t div16(input logic signed [12:0] v);
		logic signed [12:0] b;
		b = v + ((v < 0) ? 13'sd15 : 13'sd0);
		return err_t'(b >>> 4);
	endfunction

endpackage

>>> rtl/fsd_ctrl.sv
// ----------------------------------------------------------------------------
// fsd_ctrl - sequencing of one pixel
// idle, load, adjust, search over the palette (skipped when transparent), finish held while the output is busy
// ----------------------------------------------------------------------------
module fsd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          is_pixel,
	input  logic          out_busy,
	input  fsd_pkg::sts_t sts,
	output fsd_pkg::cmd_t cmd,
	output logic          idle
);
	import fsd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_LOAD   = 5'b00010,
		ST_ADJ    = 5'b00100,
		ST_SRCH   = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire && is_pixel) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_ADJ;
			ST_ADJ:  state_d = sts.skip ? ST_FIN : ST_SRCH;
			ST_SRCH: if (sts.search_last) state_d = ST_FIN;
			ST_FIN:  if (!out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign cmd.load   = (state_q == ST_LOAD);
	assign cmd.adjust = (state_q == ST_ADJ);
	assign cmd.search = (state_q == ST_SRCH);
	assign cmd.finish = (state_q == ST_FIN) && !out_busy;
	assign idle       = (state_q == ST_IDLE);

endmodule

>>> rtl/fsd_datapath.sv
// ----------------------------------------------------------------------------
// fsd_datapath - palette store, line error memory, distance unit, counters
// one palette entry compared per cycle, error terms written back at finish
// ----------------------------------------------------------------------------
module fsd_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fsd_pkg::cmd_t            cmd,
	output fsd_pkg::sts_t            sts,
	input  logic                     in_fire,
	input  logic                     operation,
	input  logic [fsd_pkg::PalW-1:0] entry_index,
	input  logic [7:0]               red,
	input  logic [7:0]               green,
	input  logic [7:0]               blue,
	input  logic [7:0]               alpha,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_idx,
	input  logic [fsd_pkg::CfgW-1:0] cfg_data,
	output logic [7:0]               res_red,
	output logic [7:0]               res_green,
	output logic [7:0]               res_blue,
	output logic [7:0]               res_alpha,
	output logic [fsd_pkg::PalW-1:0] res_entry,
	output logic                     res_quant,
	output logic                     res_fend
);
	import fsd_pkg::*;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [6:0]  psize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 13'd480;
			psize_q  <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegWidth:   width_q  <= cfg_data[10:0];
				RegHeight:  height_q <= cfg_data[12:0];
				RegPalSize: psize_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// saturated register values, zero taken as one
	logic [ColW:0] w_eff;
	logic [RowW:0] h_eff;
	logic [PalW:0] n_eff;
	always_comb begin
		w_eff = (width_q == 0) ? (ColW+1)'(1) :
			(width_q > 11'(MaxWidth)) ? (ColW+1)'(MaxWidth) : (ColW+1)'(width_q);
		h_eff = (height_q == 0) ? (RowW+1)'(1) :
			(height_q > 13'(RowLimit)) ? (RowW+1)'(RowLimit) : (RowW+1)'(height_q);
		n_eff = (psize_q == 0) ? (PalW+1)'(1) :
			(psize_q > 7'(PaletteDepth)) ? (PalW+1)'(PaletteDepth) : (PalW+1)'(psize_q);
	end

	// palette memory, synchronous read
	logic [23:0] pal_mem [PaletteDepth];
	logic [PalW-1:0] pal_raddr;
	logic [23:0] pal_rd_q;
	always_ff @(posedge clk) begin
		if (in_fire && operation == OpPalette)
			pal_mem[entry_index] <= {red, green, blue};
		pal_rd_q <= pal_mem[pal_raddr];
	end

	// line error memory
	logic [89:0] line_mem [MaxWidth];
	logic [ColW-1:0] line_raddr, line_waddr;
	logic [89:0] line_rd_q, line_wdata;
	logic line_we;
	always_ff @(posedge clk) begin
		if (line_we) line_mem[line_waddr] <= line_wdata;
		if (cmd.load) line_rd_q <= line_mem[line_raddr];
	end

	// counters and carried errors
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	err_t left_q [3];
	err_t diag_q [3];
	line_word_t prev_word_q;

	logic [7:0] pix_q [3];
	logic [7:0] alpha_q;
	logic [PalW:0] cnt_q;
	logic [PalW-1:0] best_idx_q;
	logic [17:0] best_d_q;
	logic [23:0] best_col_q;
	logic cmp_valid_q;
	logic [PalW-1:0] cmp_idx_q;

	logic first_row, last_row, last_col;
	assign first_row = (row_q == 0);
	assign last_row  = ((RowW+1)'(row_q) + 1'b1 >= h_eff);
	assign last_col  = ((ColW+1)'(col_q) + 1'b1 >= w_eff);

	assign line_raddr = col_q;
	assign pal_raddr  = cnt_q[PalW-1:0];

	// diffused adjust
	logic [7:0] adj [3];
	line_word_t rd_word;
	assign rd_word = line_rd_q;
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [7:0] v;
			v = pix_q[c];
			if (!first_row) begin
				v = clamp_byte(11'(signed'({3'b0, v})) + 11'(rd_word[c].t1));
				v = clamp_byte(11'(signed'({3'b0, v})) + 11'(rd_word[c].t5));
				v = clamp_byte(11'(signed'({3'b0, v})) + 11'(rd_word[c].t3));
			end
			adj[c] = clamp_byte(11'(signed'({3'b0, v})) + 11'(left_q[c]));
		end
	end

	// pixel latch, replaced by the adjusted color
	always_ff @(posedge clk) begin
		if (in_fire && operation == OpPixel) begin
			pix_q[0] <= red;
			pix_q[1] <= green;
			pix_q[2] <= blue;
			alpha_q  <= alpha;
		end else if (cmd.adjust) begin
			for (int c = 0; c < 3; c++) pix_q[c] <= adj[c];
		end
	end

	// distance of the entry read last cycle
	logic signed [17:0] dr, dg, db;
	logic [17:0] sq_dist;
	assign dr = 18'(pix_q[0]) - 18'(pal_rd_q[23:16]);
	assign dg = 18'(pix_q[1]) - 18'(pal_rd_q[15:8]);
	assign db = 18'(pix_q[2]) - 18'(pal_rd_q[7:0]);
	assign sq_dist = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);

	assign sts.skip        = (alpha_q == 0);
	assign sts.search_last = cmp_valid_q && ({1'b0, cmp_idx_q} == n_eff - 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.adjust) begin
			cnt_q       <= '0;
			cmp_valid_q <= 1'b0;
			best_d_q    <= '1;
			best_idx_q  <= '0;
			best_col_q  <= '0;
			cmp_idx_q   <= '0;
		end else if (cmd.search) begin
			cmp_valid_q <= (cnt_q < n_eff);
			cmp_idx_q   <= cnt_q[PalW-1:0];
			if (cnt_q < n_eff) cnt_q <= cnt_q + 1'b1;
			if (cmp_valid_q && (cmp_idx_q == '0 || sq_dist < best_d_q)) begin
				best_d_q   <= sq_dist;
				best_idx_q <= cmp_idx_q;
				best_col_q <= pal_rd_q;
			end
		end
	end
	// entry 0 always wins, later entries only on a strictly smaller distance

	// finish: error split and writeback
	err_t e7 [3], e3 [3], e5 [3], e1 [3];
	logic [7:0] fin_col [3];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic signed [12:0] e;
			fin_col[c] = sts.skip ? pix_q[c] : best_col_q[23-8*c -: 8];
			e = sts.skip ? 13'sd0 : 13'(signed'({5'b0, pix_q[c]})) - 13'(signed'({5'b0, fin_col[c]}));
			e7[c] = div16(13'(e * 7));
			e3[c] = div16(13'(e * 3));
			e5[c] = div16(13'(e * 5));
			e1[c] = div16(e);
		end
	end

	line_word_t new_word;
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			new_word[c].t1 = last_row ? err_t'(0) : diag_q[c];
			new_word[c].t5 = last_row ? err_t'(0) : e5[c];
			new_word[c].t3 = err_t'(0);
		end
	end

	// previous column's word with its down-left term filled in
	line_word_t patch_new;
	always_comb begin
		patch_new = prev_word_q;
		for (int c = 0; c < 3; c++)
			patch_new[c].t3 = last_row ? err_t'(0) : e3[c];
	end

	// write the current column, and patch the previous one's down-left term
	logic patch_q;
	logic [ColW-1:0] patch_addr_q;
	line_word_t patch_word_q;
	always_comb begin
		line_we = 1'b0;
		line_waddr = col_q;
		line_wdata = new_word;
		if (cmd.finish) begin
			line_we = 1'b1;
		end else if (patch_q) begin
			line_we = 1'b1;
			line_waddr = patch_addr_q;
			line_wdata = patch_word_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			patch_q      <= 1'b0;
			patch_addr_q <= '0;
			patch_word_q <= '0;
			prev_word_q  <= '0;
			for (int c = 0; c < 3; c++) begin
				left_q[c] <= '0;
				diag_q[c] <= '0;
			end
		end else begin
			if (!cmd.finish) patch_q <= 1'b0;
			if (cmd.finish) begin
				patch_q      <= (col_q != 0);
				patch_addr_q <= col_q - 1'b1;
				patch_word_q <= patch_new;
				for (int c = 0; c < 3; c++) begin
					diag_q[c] <= (last_row || last_col) ? err_t'(0) : e1[c];
					left_q[c] <= last_col ? err_t'(0) : e7[c];
				end
				prev_word_q <= new_word;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_red   <= fin_col[0];
			res_green <= fin_col[1];
			res_blue  <= fin_col[2];
			res_alpha <= alpha_q;
			res_entry <= sts.skip ? '0 : best_idx_q;
			res_quant <= !sts.skip;
			res_fend  <= last_col && last_row;
		end
	end

endmodule

>>> rtl/floyd_steinberg_palette_dither.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_palette_dither - error diffusion dither onto a palette
// top level joining the sequencer and the datapath
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready): a beat is a palette write (operation 0)
//   or an rgba pixel (operation 1) in raster order
//   out channel (out_valid/out_ready): one beat per pixel, none per write
//   cfg port: cfg_we, cfg_index, cfg_data, write only while idle
// timing
//   palette write: taken while idle, in_ready stays high
//   pixel: load, adjust, then one palette entry per cycle through the
//   shared distance unit, then finish, which loads the out register;
//   transparent pixels skip the search and go from adjust to finish;
//   the next pixel is taken once the result moved into the out register
// reset
//   column, row counters and carried errors clear, registers go to 640 x
//   480, 64 entries; palette and line memory hold garbage until written
// stall
//   a held out beat keeps the sequencer in finish, input waits
// ----------------------------------------------------------------------------
module floyd_steinberg_palette_dither (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [fsd_pkg::PalW-1:0] entry_index,
	input  logic [7:0]               red,
	input  logic [7:0]               green,
	input  logic [7:0]               blue,
	input  logic [7:0]               alpha,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               out_red,
	output logic [7:0]               out_green,
	output logic [7:0]               out_blue,
	output logic [7:0]               out_alpha,
	output logic [fsd_pkg::PalW-1:0] chosen_entry,
	output logic                     quantized,
	output logic                     frame_end,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [fsd_pkg::CfgW-1:0] cfg_data
);
	import fsd_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle, in_fire, out_busy;

	// accept only in idle so the line memory port is free
	assign in_ready = idle;
	assign in_fire  = in_valid && in_ready;
	// out register busy when a beat waits and is not taken now
	assign out_busy = out_valid && !out_ready;

	fsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.is_pixel (operation == OpPixel),
		.out_busy (out_busy),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	fsd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_fire     (in_fire),
		.operation   (operation),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_index),
		.cfg_data    (cfg_data),
		.res_red     (out_red),
		.res_green   (out_green),
		.res_blue    (out_blue),
		.res_alpha   (out_alpha),
		.res_entry   (chosen_entry),
		.res_quant   (quantized),
		.res_fend    (frame_end)
	);

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.finish) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	// a pixel result is never loaded over a waiting beat
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_busy) else $error("out beat overwritten");

	// input taken only while the sequencer idles
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> idle) else $error("input taken while busy");

	// commands are exclusive
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.adjust, cmd.search, cmd.finish}))
		else $error("overlapping commands");

endmodule

>>> verif/floyd_steinberg_palette_dither_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// floyd_steinberg_palette_dither_test - self-checking bench of the palette dither
// a clocked driver feeds palette writes and pixels from a queue, a predictor
// computes the dithered beat of every accepted pixel, and a clocked monitor
// compares each output beat field by field; both sides idle at random
// ----------------------------------------------------------------------------
module floyd_steinberg_palette_dither_test;
	import fsd_pkg::*;

	typedef struct {
		logic       op;
		logic [5:0] idx;
		logic [7:0] r, g, b, a;
	} beat_t;

	typedef struct {
		logic [7:0] r, g, b, a;
		logic [5:0] entry;
		logic       quant;
		logic       fend;
	} dither_t;

	logic clk, arst_n;
	logic in_valid, in_ready, operation;
	logic [PalW-1:0] entry_index;
	logic [7:0] red, green, blue, alpha;
	logic out_valid, out_ready;
	logic [7:0] out_red, out_green, out_blue, out_alpha;
	logic [PalW-1:0] chosen_entry;
	logic quantized, frame_end;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;

	floyd_steinberg_palette_dither dut (.*);

	// beats waiting for the driver, dithered beats waiting for the monitor
	beat_t   send_q[$];
	dither_t dither_q[$];
	int      errors = 0;
	int      items_sent = 0;
	bit      quiet = 0;

	// predictor state: register mirror, palette, line terms, carries, counters
	int width_reg = 640, height_reg = 480, pal_reg = 64;
	int pal_rgb[PaletteDepth][3];
	int up_left[MaxWidth][3], up_mid[MaxWidth][3], up_right[MaxWidth][3];
	int carry_right[3], carry_diag[3];
	int col = 0, row = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// generous fixed limit on the whole run
	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int sat(int v);
		return v < 0 ? 0 : (v > 255 ? 255 : v);
	endfunction

	// idle length per beat, with bursts of no idling now and then
	function automatic int draw_gap();
		if ($urandom_range(0, 39) == 0) quiet = ~quiet;
		return quiet ? 0 : $urandom_range(0, 14);
	endfunction

	// dither one accepted beat and queue the beat it must produce
	function automatic void dither_beat(beat_t it);
		int w, h, n, x, best, d, pick, c, i;
		int pix[3], e[3], res[3];
		bit top, bottom, edge_r;
		dither_t o;
		if (it.op == OpPalette) begin
			pal_rgb[it.idx][0] = it.r;
			pal_rgb[it.idx][1] = it.g;
			pal_rgb[it.idx][2] = it.b;
			return;
		end
		w = width_reg == 0 ? 1 : (width_reg > MaxWidth ? MaxWidth : width_reg);
		h = height_reg == 0 ? 1 : (height_reg > RowLimit ? RowLimit : height_reg);
		n = pal_reg == 0 ? 1 : (pal_reg > PaletteDepth ? PaletteDepth : pal_reg);
		x = col;
		top = (row == 0);
		bottom = (row + 1 >= h);
		edge_r = (x + 1 >= w);
		pix[0] = it.r; pix[1] = it.g; pix[2] = it.b;
		// terms from above first, then the one from the left, clamped each time
		for (c = 0; c < 3; c++) begin
			if (!top) begin
				pix[c] = sat(pix[c] + up_left[x][c]);
				pix[c] = sat(pix[c] + up_mid[x][c]);
				pix[c] = sat(pix[c] + up_right[x][c]);
			end
			pix[c] = sat(pix[c] + carry_right[c]);
		end
		pick = 0;
		if (it.a != 0) begin
			best = -1;
			for (i = 0; i < n; i++) begin
				d = (pix[0] - pal_rgb[i][0]) ** 2 + (pix[1] - pal_rgb[i][1]) ** 2
					+ (pix[2] - pal_rgb[i][2]) ** 2;
				// strict compare, so the lowest index wins a tie
				if (best < 0 || d < best) begin
					best = d;
					pick = i;
				end
			end
			for (c = 0; c < 3; c++) begin
				res[c] = pal_rgb[pick][c];
				e[c] = pix[c] - res[c];
			end
		end else begin
			// transparent: colour passes, no error spread
			for (c = 0; c < 3; c++) begin
				res[c] = pix[c];
				e[c] = 0;
			end
		end
		for (c = 0; c < 3; c++) begin
			if (x > 0) up_right[x - 1][c] = bottom ? 0 : e[c] * 3 / 16;
			up_left[x][c] = bottom ? 0 : carry_diag[c];
			up_mid[x][c] = bottom ? 0 : e[c] * 5 / 16;
			up_right[x][c] = 0;
			carry_diag[c] = (bottom || edge_r) ? 0 : e[c] / 16;
			carry_right[c] = edge_r ? 0 : e[c] * 7 / 16;
		end
		o.fend = 0;
		if (edge_r) begin
			col = 0;
			if (bottom) begin
				row = 0;
				o.fend = 1;
			end else row++;
		end else col = x + 1;
		o.r = 8'(res[0]); o.g = 8'(res[1]); o.b = 8'(res[2]);
		o.a = it.a;
		o.entry = 6'(pick);
		o.quant = (it.a != 0);
		dither_q.push_back(o);
	endfunction

	// driver: one valid update per edge, next beat follows its drawn gap
	beat_t cur;
	int    in_gap = 0;
	always @(posedge clk) begin
		logic v_next;
		if (arst_n) begin
			v_next = in_valid;
			if (in_valid && in_ready) begin
				dither_beat(cur);
				v_next = 0;
				in_gap = draw_gap();
			end
			if (!v_next) begin
				if (in_gap > 0) in_gap--;
				else if (send_q.size() > 0) begin
					cur = send_q.pop_front();
					operation <= cur.op;
					entry_index <= cur.idx;
					red <= cur.r;
					green <= cur.g;
					blue <= cur.b;
					alpha <= cur.a;
					v_next = 1;
				end
			end
			in_valid <= v_next;
		end
	end

	function automatic void check_field(string name, int e, int a);
		if (e != a) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, e, a);
			errors++;
		end
	endfunction

	// monitor: compare each accepted out beat, then stall a drawn while
	int out_stall = 0;
	always @(posedge clk) begin
		dither_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (dither_q.size() == 0) begin
					$display("%0t unexpected out beat: expected none actual r%0d g%0d b%0d",
						$time, out_red, out_green, out_blue);
					errors++;
				end else begin
					e = dither_q.pop_front();
					check_field("out_red", e.r, out_red);
					check_field("out_green", e.g, out_green);
					check_field("out_blue", e.b, out_blue);
					check_field("out_alpha", e.a, out_alpha);
					check_field("chosen_entry", e.entry, chosen_entry);
					check_field("quantized", e.quant, quantized);
					check_field("frame_end", e.fend, frame_end);
				end
				out_stall = draw_gap();
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 0;
			end else out_ready <= 1;
		end
	end

	task automatic write_reg(logic [1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= CfgW'(val);
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			RegWidth:   width_reg = val & 'h7ff;
			RegHeight:  height_reg = val & 'h1fff;
			RegPalSize: pal_reg = val & 'h7f;
			default: ;
		endcase
	endtask

	task automatic set_regs(int w, int h, int p);
		write_reg(RegWidth, w);
		write_reg(RegHeight, h);
		write_reg(RegPalSize, p);
	endtask

	function automatic void push_entry(int idx, int r, int g, int b);
		beat_t it;
		it.op = OpPalette; it.idx = 6'(idx);
		it.r = 8'(r); it.g = 8'(g); it.b = 8'(b); it.a = 8'($urandom);
		send_q.push_back(it);
		items_sent++;
	endfunction

	function automatic void push_pixel(int r, int g, int b, int a);
		beat_t it;
		it.op = OpPixel; it.idx = 6'($urandom);
		it.r = 8'(r); it.g = 8'(g); it.b = 8'(b); it.a = 8'(a);
		send_q.push_back(it);
		items_sent++;
	endfunction

	// channel value leaning on the clamp edges
	function automatic int chan();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic int rand_alpha();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 255;
			default: return $urandom_range(1, 255);
		endcase
	endfunction

	int pal_rgb_next[PaletteDepth][3];

	// fill all entries, some duplicated so ties come up
	function automatic void load_palette();
		int i;
		for (i = 0; i < PaletteDepth; i++) begin
			if (i > 0 && $urandom_range(0, 5) == 0)
				push_entry(i, pal_rgb_next[i - 1][0], pal_rgb_next[i - 1][1],
					pal_rgb_next[i - 1][2]);
			else begin
				pal_rgb_next[i][0] = chan();
				pal_rgb_next[i][1] = chan();
				pal_rgb_next[i][2] = chan();
				push_entry(i, pal_rgb_next[i][0], pal_rgb_next[i][1], pal_rgb_next[i][2]);
				continue;
			end
			pal_rgb_next[i] = pal_rgb_next[i - 1];
		end
	endfunction

	// block is idle once the queues are empty and the last beat has left
	task automatic drain();
		while (send_q.size() > 0 || in_valid || dither_q.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		int i, w, h, p, frames, k;
		arst_n = 0;
		in_valid = 0;
		operation = 0;
		entry_index = 0;
		red = 0; green = 0; blue = 0; alpha = 0;
		out_ready = 0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: default registers, extremes on row zero
		push_entry(0, 0, 0, 0);
		push_entry(1, 0, 0, 0);                 // tie with entry 0
		push_entry(2, 255, 255, 255);
		for (i = 3; i < PaletteDepth; i++) push_entry(i, i * 4, 255 - i * 4, i * 3);
		push_pixel(0, 0, 0, 255);
		push_pixel(255, 255, 255, 1);
		push_pixel(128, 7, 200, 0);             // transparent pass-through
		push_pixel(255, 0, 255, 255);
		push_pixel(1, 254, 3, 0);
		push_pixel(90, 90, 90, 200);
		drain();
		// shrink mid-frame: column 6 beyond the new last column, palette size 0
		set_regs(3, 2, 0);
		push_pixel(200, 10, 30, 255);
		push_pixel(0, 0, 0, 255);
		push_pixel(255, 255, 255, 0);
		push_pixel(40, 250, 5, 9);
		drain();
		// oversized values saturate
		set_regs(2047, 8191, 127);
		push_pixel(255, 255, 255, 255);
		push_pixel(0, 0, 0, 255);
		push_entry(63, 10, 20, 30);
		push_pixel(10, 20, 30, 255);
		push_pixel(7, 7, 7, 0);
		push_pixel(250, 3, 128, 77);
		drain();
		// zero width and height end row and frame at once
		set_regs(0, 0, 64);
		push_pixel(33, 66, 99, 255);
		drain();

		// random frames, at frame boundaries only
		k = 0;
		while (items_sent < 1850) begin
			if (k == 3) begin
				w = 1024; h = 1;
			end else begin
				w = $urandom_range(0, 7) == 0 ? $urandom_range(0, 40) : $urandom_range(1, 12);
				h = $urandom_range(0, 6);
			end
			case ($urandom_range(0, 4))
				0: p = 1;
				1: p = 64;
				2: p = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
				default: p = $urandom_range(1, 64);
			endcase
			set_regs(w, h, p);
			load_palette();
			w = w == 0 ? 1 : w;
			h = h == 0 ? 1 : h;
			frames = (w * h > 200) ? 1 : $urandom_range(1, 3);
			for (i = 0; i < frames * w * h; i++) begin
				if ($urandom_range(0, 19) == 0)
					push_entry($urandom_range(0, 63), chan(), chan(), chan());
				push_pixel(chan(), chan(), chan(), rand_alpha());
			end
			drain();
			k++;
		end

		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

endmodule
